### rtl/ipwf_pkg.sv
// Shared constants, types and helpers of the infix-not-prefix word filter.
package ipwf_pkg;

    localparam int DEF_MAX_PATTERN  = 16;
    localparam int DEF_MAX_WORD_LEN = 255;
    localparam int DEF_MAX_ENTRIES  = 65536;

    localparam int CHAR_W      = 8;
    localparam int ENTRY_W     = 17;
    localparam int QUALITY_W   = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int PLEN_REG_W  = 5;
    localparam int NUM_SHIFT   = 15;   // numerator is plen * 32768
    localparam int CHARS_PER_WORD = CFG_DATA_W / CHAR_W;

    localparam logic [QUALITY_W-1:0] Q_BASE = 16'd42598;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic step;    // a character of the word is consumed
        logic clear;   // the word ends
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;     // whole pattern ends at this character
        logic miss;    // prefix check fails at this position
    } cell_stat_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### rtl/ipwf_char_if.sv
// Character item channel.
interface ipwf_char_if;
    import ipwf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_word;
    logic              empty_word;
    logic              first_of_list;

    modport source (output valid, output char_code, output last_of_word,
                    output empty_word, output first_of_list, input ready);
    modport sink   (input valid, input char_code, input last_of_word,
                    input empty_word, input first_of_list, output ready);
endinterface

### rtl/ipwf_result_if.sv
// Result item channel.
interface ipwf_result_if;
    import ipwf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ENTRY_W-1:0]   entry_id;
    logic [QUALITY_W-1:0] quality_q16;

    modport source (output valid, output entry_id, output quality_q16, input ready);
    modport sink   (input valid, input entry_id, input quality_q16, output ready);
endinterface

### rtl/infix_not_prefix_word_filter_core.sv
// Top level of the infix-not-prefix word filter.
// Words stream in one character item per cycle; a row of MAX_PATTERN cells holds the
// shift-and match bits, one pattern position each, with case folding of A-Z. A word is
// selected when it contains the pattern but does not start with it; its entry number
// and quality 42598 + floor(32768*plen/(5*len)) come out of a bit-serial divider and its
// output register. Characters keep flowing while the divider runs or holds its result;
// only a further end-of-word item waits while the divider runs or its result is not taken.
module infix_not_prefix_word_filter_core #(
    parameter int MAX_PATTERN  = ipwf_pkg::DEF_MAX_PATTERN,
    parameter int MAX_WORD_LEN = ipwf_pkg::DEF_MAX_WORD_LEN,
    parameter int MAX_ENTRIES  = ipwf_pkg::DEF_MAX_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ipwf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipwf_pkg::CFG_DATA_W-1:0]  cfg_data,
    ipwf_char_if.sink                        chars,
    ipwf_result_if.source                    results
);
    import ipwf_pkg::*;

    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int WLW = $clog2(MAX_WORD_LEN + 1);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);

    logic [CFG_DATA_W-1:0] pat_low_reg, pat_high_reg;
    logic [PLEN_REG_W-1:0] pat_len_reg;
    logic [WLW-1:0]        wlc_reg, wlc_next;
    logic                  found_reg, found_next;
    logic                  prefix_reg, prefix_next;
    logic [ECW-1:0]        ec_reg, ec_next, ec_base, id;
    logic [PLW-1:0]        plen;
    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [MAX_PATTERN-1:0]  bits;
    logic [MAX_PATTERN-1:0]  hits;
    logic [MAX_PATTERN-1:0]  misses;
    logic [CHAR_W-1:0]     char_fold;
    logic                  end_item, accept, step, starts, hit, start, div_busy;
    cell_ctrl_t            ctrl;

    assign end_item     = chars.last_of_word || chars.empty_word;
    assign chars.ready  = !end_item || !div_busy;
    assign accept       = chars.valid && chars.ready;
    assign step         = accept && !chars.empty_word;
    assign ctrl.step    = step;
    assign ctrl.clear   = accept && end_item;
    assign char_fold    = fold_case(chars.char_code);
    assign pat_all      = {pat_high_reg, pat_low_reg};
    assign plen         = (pat_len_reg > PLEN_REG_W'(MAX_PATTERN)) ?
                          PLW'(MAX_PATTERN) : PLW'(pat_len_reg);

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        cell_stat_t stat;
        ipwf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .char_fold (char_fold),
            .pat_char  (fold_case(pat_all[CHAR_W*i +: CHAR_W])),
            .active    (plen > PLW'(i)),
            .tail      (plen == PLW'(i + 1)),
            .at_pos    (wlc_reg == WLW'(i)),
            .prev_bit  ((i == 0) ? 1'b1 : bits[(i == 0) ? 0 : i - 1]),
            .match_bit (bits[i]),
            .stat      (stat)
        );
        assign hits[i]   = stat.hit;
        assign misses[i] = stat.miss;
    end

    always_comb
    begin
        wlc_next    = wlc_reg;
        found_next  = found_reg;
        prefix_next = prefix_reg;
        if (step)
        begin
            found_next  = found_reg || (|hits);
            prefix_next = prefix_reg && !(|misses);
            if (wlc_reg < WLW'(MAX_WORD_LEN))
            begin
                wlc_next = wlc_reg + 1'b1;
            end
        end
    end

    assign ec_base = chars.first_of_list ? '0 : ec_reg;
    assign id      = (ec_base < ECW'(MAX_ENTRIES)) ? ec_base + 1'b1 : ECW'(MAX_ENTRIES);
    assign starts  = prefix_next && (wlc_next >= WLW'(plen));
    assign hit     = (plen != '0) && found_next && !starts && (wlc_next != '0);
    assign start   = accept && end_item && hit;

    always_comb
    begin
        ec_next = ec_reg;
        if (accept)
        begin
            ec_next = end_item ? id : ec_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            wlc_reg      <= '0;
            found_reg    <= 1'b0;
            prefix_reg   <= 1'b1;
            ec_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                    CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                    CFG_PATTERN_LEN:  pat_len_reg  <= cfg_data[PLEN_REG_W-1:0];
                    default:          ;
                endcase
            end
            ec_reg <= ec_next;
            if (accept && end_item)
            begin
                wlc_reg    <= '0;
                found_reg  <= 1'b0;
                prefix_reg <= 1'b1;
            end
            else
            begin
                wlc_reg    <= wlc_next;
                found_reg  <= found_next;
                prefix_reg <= prefix_next;
            end
        end
    end

    ipwf_div #(
        .PLW (PLW),
        .WLW (WLW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .plen    (plen),
        .wlen    (wlc_next),
        .id      (ENTRY_W'(id)),
        .busy    (div_busy),
        .results (results)
    );

endmodule

### rtl/ipwf_cell.sv
// One pattern position: shift-and match bit and prefix check.
module ipwf_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ipwf_pkg::cell_ctrl_t      ctrl,
    input  logic [ipwf_pkg::CHAR_W-1:0] char_fold,
    input  logic [ipwf_pkg::CHAR_W-1:0] pat_char,
    input  logic                      active,
    input  logic                      tail,
    input  logic                      at_pos,
    input  logic                      prev_bit,
    output logic                      match_bit,
    output ipwf_pkg::cell_stat_t      stat
);
    import ipwf_pkg::*;

    logic bit_reg;
    logic bit_next;
    logic eq;
    logic match;

    assign eq    = active && (char_fold == pat_char);
    assign match = prev_bit && eq;

    always_comb
    begin
        bit_next = bit_reg;
        if (ctrl.step)
        begin
            bit_next = match;
        end
        if (ctrl.clear)
        begin
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign match_bit = bit_reg;
    assign stat.hit  = ctrl.step && match && tail;
    assign stat.miss = ctrl.step && at_pos && active && !eq;

endmodule

### rtl/ipwf_div.sv
// Bit-serial quality divider with output register.
module ipwf_div #(
    parameter int PLW = 5,
    parameter int WLW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [PLW-1:0]               plen,
    input  logic [WLW-1:0]               wlen,
    input  logic [ipwf_pkg::ENTRY_W-1:0] id,
    output logic                         busy,
    ipwf_result_if.source                results
);
    import ipwf_pkg::*;

    localparam int NW = PLW + NUM_SHIFT;
    localparam int DW = WLW + 3;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]        num_reg, num_next;
    logic [NW-1:0]        quo_reg, quo_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        den_reg, den_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0]   id_reg, id_next;
    logic [QUALITY_W-1:0] q_reg, q_next;
    logic [DW:0]          trial;
    logic                 ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        id_next        = id_reg;
        q_next         = q_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (start)
        begin
            num_next = {plen, {NUM_SHIFT{1'b0}}};
            quo_next = '0;
            rem_next = '0;
            den_next = {wlen, 2'b00} + DW'(wlen);
            cnt_next = CW'(NW);
            run_next = 1'b1;
            id_next  = id;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next       = 1'b0;
                out_valid_next = 1'b1;
                q_next         = Q_BASE + QUALITY_W'({quo_reg[NW-2:0], ge});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        id_reg  <= id_next;
        q_reg   <= q_next;
    end

    assign busy                = run_reg || out_valid_reg;
    assign results.valid       = out_valid_reg;
    assign results.entry_id    = id_reg;
    assign results.quality_q16 = q_reg;

endmodule
